### hw/rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants and types for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS    = 48;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_KILL   = 8'h15;
  localparam logic [7:0] CH_WERASE = 8'h17;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_line;
    logic       last;
  } tle_res_t;

endpackage

### hw/rtl/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical-mode line editor: echo, erase, kill, word erase and line output.
//
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata = rx_char
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata = out_byte, tuser = is_line,
//                                              tlast = last
//
// One input transaction at a time; at most one result per cycle from a single
// output register. Ordinary char: stored and echoed if room. BS/DEL: BS SP BS.
// Ctrl-U: three results per erased byte. Ctrl-W: backward scan, one store read
// per byte, then three results per erased byte. CR: each line byte costs a
// store read and an emit. Output stalls hold the sequencer. Reset clears count, not store.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
  parameter int LineDepth = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] is_line
  output logic       m_axis_tlast
);
  import tle_pkg::*;

  tle_res_t res;
  logic     res_valid, res_ready;

  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_line_q;
  logic       out_last_q;

  tle_core #(
    .LineDepth(LineDepth)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_byte_q <= res.out_byte;
      out_line_q <= res.is_line;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_line_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hw/rtl/tle_core.sv
// ----------------------------------------------------------------------------
// tle_core
// Line store, count and result sequencer of the terminal line editor.
// ----------------------------------------------------------------------------
module tle_core #(
  parameter int LineDepth = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_char_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output tle_pkg::tle_res_t res_o
);
  import tle_pkg::*;

  localparam int CntW  = $clog2(LineDepth + 1);
  localparam int AddrW = $clog2(LineDepth);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_ERASE = 4'd2;
  localparam logic [3:0] S_CHR   = 4'd3;
  localparam logic [3:0] S_ECR   = 4'd4;
  localparam logic [3:0] S_ELF   = 4'd5;
  localparam logic [3:0] S_LRD   = 4'd6;
  localparam logic [3:0] S_LEM   = 4'd7;
  localparam logic [3:0] S_LCR   = 4'd8;
  localparam logic [3:0] S_EHASH = 4'd9;
  localparam logic [3:0] S_ESP   = 4'd10;

  localparam logic [1:0] PH_BS1 = 2'd0;
  localparam logic [1:0] PH_SP  = 2'd1;
  localparam logic [1:0] PH_BS2 = 2'd2;

  logic [7:0]     mem [LineDepth];
  logic [7:0]     rd_q;

  logic [3:0]     state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] stop_q, stop_d;
  logic [1:0]     phase_q, phase_d;
  logic [7:0]     chr_q, chr_d;
  logic [RES_CNT_W-1:0] res_cnt_q, res_cnt_d;

  logic           accept, emit, nat_last, cap_last;
  logic           we, re;
  logic [AddrW-1:0] wa, ra;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign emit        = res_valid_o && res_ready_i;
  assign cap_last    = (res_cnt_q == RES_CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    res_valid_o    = 1'b0;
    res_o.out_byte = CH_BS;
    res_o.is_line  = 1'b0;
    nat_last       = 1'b0;
    case (state_q)
      S_ERASE: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = (phase_q == PH_SP) ? CH_SPACE : CH_BS;
        nat_last       = (phase_q == PH_BS2) && (k_q == n_q - CntW'(1));
      end
      S_CHR: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = chr_q;
        nat_last       = 1'b1;
      end
      S_ECR: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = CH_CR;
      end
      S_ELF: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = CH_LF;
      end
      S_LEM: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = rd_q;
        res_o.is_line  = 1'b1;
      end
      S_LCR: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = CH_CR;
        res_o.is_line  = 1'b1;
      end
      S_EHASH: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = CH_HASH;
      end
      S_ESP: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = CH_SPACE;
        nat_last       = 1'b1;
      end
      default: ;
    endcase
    res_o.last = nat_last || cap_last;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    k_d       = k_q;
    idx_d     = idx_q;
    stop_d    = stop_q;
    phase_d   = phase_q;
    chr_d     = chr_q;
    res_cnt_d = res_cnt_q;
    we        = 1'b0;
    wa        = count_q[AddrW-1:0];
    re        = 1'b0;
    ra        = stop_q;

    if (emit) begin
      res_cnt_d = res_cnt_q + RES_CNT_W'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_cnt_d = '0;
          k_d       = '0;
          phase_d   = PH_BS1;
          chr_d     = in_char_i;
          if (in_char_i == CH_NUL || in_char_i == CH_ESC) begin
            state_d = S_IDLE;
          end else if (in_char_i == CH_BS || in_char_i == CH_DEL) begin
            n_d     = CntW'(1);
            state_d = S_ERASE;
            if (count_q != '0) begin
              count_d = count_q - CntW'(1);
            end
          end else if (in_char_i == CH_KILL) begin
            if (count_q != '0) begin
              n_d     = count_q;
              count_d = '0;
              state_d = S_ERASE;
            end
          end else if (in_char_i == CH_WERASE) begin
            if (count_q == CntW'(1)) begin
              n_d     = count_q;
              count_d = '0;
              state_d = S_ERASE;
            end else if (count_q != '0) begin
              stop_d  = AddrW'(count_q - CntW'(1));
              re      = 1'b1;
              ra      = AddrW'(count_q - CntW'(1));
              state_d = S_SCAN;
            end
          end else if (in_char_i == CH_CR) begin
            n_d     = count_q;
            count_d = '0;
            state_d = S_ECR;
          end else if (count_q < CntW'(LineDepth)) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
            state_d = S_CHR;
          end
        end
      end
      S_SCAN: begin
        if (rd_q == CH_SPACE) begin
          n_d     = count_q - CntW'(stop_q);
          count_d = CntW'(stop_q);
          state_d = S_ERASE;
        end else if (stop_q == AddrW'(1)) begin
          n_d     = count_q;
          count_d = '0;
          state_d = S_ERASE;
        end else begin
          stop_d = stop_q - AddrW'(1);
          re     = 1'b1;
          ra     = stop_q - AddrW'(1);
        end
      end
      S_LRD: begin
        re      = 1'b1;
        ra      = idx_q[AddrW-1:0];
        state_d = S_LEM;
      end
      default: begin
        if (emit) begin
          if (res_o.last) begin
            state_d = S_IDLE;
          end else begin
            case (state_q)
              S_ERASE: begin
                if (k_q == n_q - CntW'(1)) begin
                  k_d     = '0;
                  phase_d = phase_q + 2'd1;
                end else begin
                  k_d = k_q + CntW'(1);
                end
              end
              S_ECR: state_d = S_ELF;
              S_ELF: begin
                idx_d   = '0;
                state_d = (n_q == '0) ? S_LCR : S_LRD;
              end
              S_LEM: begin
                idx_d   = idx_q + CntW'(1);
                state_d = (idx_q + CntW'(1) == n_q) ? S_LCR : S_LRD;
              end
              S_LCR:   state_d = S_EHASH;
              S_EHASH: state_d = S_ESP;
              default: state_d = S_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= in_char_i;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      res_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    stop_q  <= stop_d;
    phase_q <= phase_d;
    chr_q   <= chr_d;
  end

endmodule
